@@ rtl/aarm_pkg.sv @@
// Package for the axis-angle to rotation matrix unit.
// CORDIC word format, angle constants, arctangent table and the cell payload type.
// No dependencies.
`timescale 1ns / 1ps

package aarm_pkg;

  // CORDIC datapath: Q3.30 words, wide enough for the unfolded angle
  localparam int CW           = 34;
  localparam int INT_FRAC     = 30;
  localparam int CORDIC_ITERS = 30;

  // pipeline depths of the two halves
  localparam int SINCOS_LAT = CORDIC_ITERS + 2;
  localparam int MATRIX_LAT = 5;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(32'h26DD3B6A);
  localparam logic signed [CW-1:0] PI_Q30      = CW'(64'd3373259426);
  localparam logic signed [CW-1:0] HALF_PI_Q30 = CW'(64'd1686629713);

  // atan(2^-i), Q2.30, truncated
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // state handed from one CORDIC cell to the next
  typedef struct packed {
    logic                 flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

endpackage

@@ rtl/aarm_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation, registered.
// Shift and arctangent are fixed by STAGE. Uses aarm_pkg.
`timescale 1ns / 1ps

module aarm_cordic_cell #(
  parameter int STAGE = 0,
  parameter int AUX_W = 48
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  aarm_pkg::cordic_t cell_i,
  input  logic [AUX_W-1:0]  aux_i,
  output aarm_pkg::cordic_t cell_o,
  output logic [AUX_W-1:0]  aux_o
);
  import aarm_pkg::*;

  localparam logic signed [CW-1:0] ATAN_C = CW'(ATAN_Q30[STAGE]);

  cordic_t cell_d;

  always_comb begin
    logic signed [CW-1:0] x, y, z, dx, dy;
    x  = cell_i.x;
    y  = cell_i.y;
    z  = cell_i.z;
    dx = y >>> STAGE;
    dy = x >>> STAGE;
    cell_d.flip = cell_i.flip;
    if (!z[CW-1]) begin
      cell_d.x = x - dx;
      cell_d.y = y + dy;
      cell_d.z = z - ATAN_C;
    end else begin
      cell_d.x = x + dx;
      cell_d.y = y - dy;
      cell_d.z = z + ATAN_C;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_o <= cell_d;
      aux_o  <= aux_i;
    end
  end

endmodule

@@ rtl/aarm_sincos.sv @@
// Sine and cosine: quadrant fold, chain of CORDIC cells, rounding to Q1.FRAC.
// Carries a side payload along the chain. Uses aarm_pkg and aarm_cordic_cell.
`timescale 1ns / 1ps

module aarm_sincos #(
  parameter int VB    = 16,
  parameter int AUX_W = 48
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [VB-1:0] angle_i,
  input  logic [AUX_W-1:0]     aux_i,
  output logic signed [VB-1:0] cos_o,
  output logic signed [VB-1:0] sin_o,
  output logic [AUX_W-1:0]     aux_o
);
  import aarm_pkg::*;

  localparam int FRAC = VB - 2;
  localparam int ASH  = INT_FRAC - (VB - 3);
  localparam int SH   = INT_FRAC - FRAC;
  localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< FRAC;

  cordic_t          chain [CORDIC_ITERS+1];
  logic [AUX_W-1:0] aux_chain [CORDIC_ITERS+1];
  cordic_t          fold_d;

  // fold into [-pi/2, pi/2]; cosine sign restored at the end
  always_comb begin
    logic signed [CW-1:0] z0;
    z0 = CW'(angle_i) <<< ASH;
    fold_d.x    = CORDIC_GAIN;
    fold_d.y    = '0;
    fold_d.flip = 1'b0;
    fold_d.z    = z0;
    if (z0 > HALF_PI_Q30) begin
      fold_d.z    = PI_Q30 - z0;
      fold_d.flip = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      fold_d.z    = -PI_Q30 - z0;
      fold_d.flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chain[0]     <= fold_d;
      aux_chain[0] <= aux_i;
    end
  end

  for (genvar gi = 0; gi < CORDIC_ITERS; gi++) begin : g_cell
    aarm_cordic_cell #(
      .STAGE (gi),
      .AUX_W (AUX_W)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .cell_i (chain[gi]),
      .aux_i  (aux_chain[gi]),
      .cell_o (chain[gi+1]),
      .aux_o  (aux_chain[gi+1])
    );
  end

  logic signed [CW-1:0] xf, yf, xr, yr;

  assign xf = chain[CORDIC_ITERS].flip ? -chain[CORDIC_ITERS].x : chain[CORDIC_ITERS].x;
  assign yf = chain[CORDIC_ITERS].y;

  // round half up to FRAC bits
  if (SH > 0) begin : g_rnd
    localparam logic signed [CW-1:0] RND = CW'(1) <<< (SH - 1);
    logic signed [CW-1:0] xs, ys;
    assign xs = xf + RND;
    assign ys = yf + RND;
    assign xr = xs >>> SH;
    assign yr = ys >>> SH;
  end else begin : g_nornd
    assign xr = xf;
    assign yr = yf;
  end

  logic signed [VB-1:0] cos_d, sin_d;

  always_comb begin
    logic signed [CW-1:0] xc, yc;
    xc = (xr > ONE_C) ? ONE_C : ((xr < -ONE_C) ? -ONE_C : xr);
    yc = (yr > ONE_C) ? ONE_C : ((yr < -ONE_C) ? -ONE_C : yr);
    cos_d = xc[VB-1:0];
    sin_d = yc[VB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= cos_d;
      sin_o <= sin_d;
      aux_o <= aux_chain[CORDIC_ITERS];
    end
  end

endmodule

@@ rtl/aarm_matrix.sv @@
// Rodrigues matrix assembly: outer products, scaling by 1-cos, cross terms, saturation.
// Five register stages; the multipliers sit in the first and third stages. Uses aarm_pkg.
`timescale 1ns / 1ps

module aarm_matrix #(
  parameter int VB = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [VB-1:0] ux_i,
  input  logic signed [VB-1:0] uy_i,
  input  logic signed [VB-1:0] uz_i,
  input  logic signed [VB-1:0] cos_i,
  input  logic signed [VB-1:0] sin_i,
  output logic signed [VB-1:0] m_o [9]
);
  import aarm_pkg::*;

  localparam int FRAC = VB - 2;
  localparam int PW   = 2 * VB;      // first product
  localparam int QW   = 2 * VB + 3;  // second product
  localparam int TW   = VB + 3;      // scaled outer term

  localparam logic signed [VB:0]   ONE_W = (VB+1)'(1) <<< FRAC;
  localparam logic signed [PW:0]   LIM4  = (PW+1)'(1) <<< VB;
  localparam logic signed [PW:0]   HALF1 = (PW+1)'(1) <<< (FRAC - 1);
  localparam logic signed [QW:0]   HALF2 = (QW+1)'(1) <<< (FRAC - 1);
  localparam logic signed [TW-1:0] ONE_T = TW'(1) <<< FRAC;

  // a*b/ONE rounded half away from zero
  function automatic logic signed [PW:0] rnd1(input logic signed [PW-1:0] p);
    logic signed [PW:0] sum;
    sum = (PW+1)'(p) + HALF1 - (PW+1)'(p[PW-1]);
    return sum >>> FRAC;
  endfunction

  function automatic logic signed [QW:0] rnd2(input logic signed [QW-1:0] p);
    logic signed [QW:0] sum;
    sum = (QW+1)'(p) + HALF2 - (QW+1)'(p[QW-1]);
    return sum >>> FRAC;
  endfunction

  function automatic logic signed [VB-1:0] sat(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] c;
    c = (v > ONE_T) ? ONE_T : ((v < -ONE_T) ? -ONE_T : v);
    return c[VB-1:0];
  endfunction

  // outer order: xx yy zz xy xz yz; cross order: x*s y*s z*s
  logic signed [PW-1:0] pa_q [6];
  logic signed [PW-1:0] sa_q [3];
  logic signed [VB-1:0] ca_q;
  logic signed [VB:0]   cca_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q[0] <= ux_i * ux_i;
      pa_q[1] <= uy_i * uy_i;
      pa_q[2] <= uz_i * uz_i;
      pa_q[3] <= ux_i * uy_i;
      pa_q[4] <= ux_i * uz_i;
      pa_q[5] <= uy_i * uz_i;
      sa_q[0] <= ux_i * sin_i;
      sa_q[1] <= uy_i * sin_i;
      sa_q[2] <= uz_i * sin_i;
      ca_q    <= cos_i;
      cca_q   <= ONE_W - (VB+1)'(cos_i);
    end
  end

  // stage B: round, clamp outer products to +-4.0
  logic signed [VB+1:0] ob_d [6];
  logic signed [VB:0]   sb_d [3];
  logic signed [VB+1:0] ob_q [6];
  logic signed [VB:0]   sb_q [3];
  logic signed [VB-1:0] cb_q;
  logic signed [VB:0]   ccb_q;

  always_comb begin
    logic signed [PW:0] r;
    for (int k = 0; k < 6; k++) begin
      r = rnd1(pa_q[k]);
      if (r > LIM4) r = LIM4;
      else if (r < -LIM4) r = -LIM4;
      ob_d[k] = r[VB+1:0];
    end
    for (int k = 0; k < 3; k++) begin
      r = rnd1(sa_q[k]);
      sb_d[k] = r[VB:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ob_q  <= ob_d;
      sb_q  <= sb_d;
      cb_q  <= ca_q;
      ccb_q <= cca_q;
    end
  end

  // stage C: scale by 1 - cos
  logic signed [QW-1:0] pc_q [6];
  logic signed [VB:0]   sc_q [3];
  logic signed [VB-1:0] cc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        pc_q[k] <= ob_q[k] * ccb_q;
      end
      sc_q <= sb_q;
      cc_q <= cb_q;
    end
  end

  // stage D: round scaled terms
  logic signed [TW-1:0] td_d [6];
  logic signed [TW-1:0] td_q [6];
  logic signed [VB:0]   sd_q [3];
  logic signed [VB-1:0] cd_q;

  always_comb begin
    logic signed [QW:0] r;
    for (int k = 0; k < 6; k++) begin
      r = rnd2(pc_q[k]);
      td_d[k] = r[TW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      td_q <= td_d;
      sd_q <= sc_q;
      cd_q <= cc_q;
    end
  end

  // stage E: combine and saturate, this is the output register
  logic signed [VB-1:0] m_d [9];
  logic signed [TW-1:0] c_t;
  logic signed [TW-1:0] xs_t, ys_t, zs_t;

  assign c_t  = TW'(cd_q);
  assign xs_t = TW'(sd_q[0]);
  assign ys_t = TW'(sd_q[1]);
  assign zs_t = TW'(sd_q[2]);

  always_comb begin
    m_d[0] = sat(td_q[0] + c_t);
    m_d[1] = sat(td_q[3] - zs_t);
    m_d[2] = sat(td_q[4] + ys_t);
    m_d[3] = sat(td_q[3] + zs_t);
    m_d[4] = sat(td_q[1] + c_t);
    m_d[5] = sat(td_q[5] - xs_t);
    m_d[6] = sat(td_q[4] - ys_t);
    m_d[7] = sat(td_q[5] + xs_t);
    m_d[8] = sat(td_q[2] + c_t);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_o <= m_d;
    end
  end

endmodule

@@ rtl/axis_angle_to_rotation_matrix_unit.sv @@
// Axis-angle to rotation matrix. Pipeline: fold, 30 CORDIC cells, round,
// then five matrix stages; the depth is the sum of the two halves.
// Throughput one beat per cycle; a stalled output beat freezes the whole pipeline.
// Reset clears only the stage valid flags. Uses aarm_pkg, aarm_sincos, aarm_matrix.
`timescale 1ns / 1ps

module axis_angle_to_rotation_matrix_unit #(
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] axis_x_i,
  input  logic signed [VALUE_BITS-1:0] axis_y_i,
  input  logic signed [VALUE_BITS-1:0] axis_z_i,
  input  logic signed [VALUE_BITS-1:0] angle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] m00_o,
  output logic signed [VALUE_BITS-1:0] m01_o,
  output logic signed [VALUE_BITS-1:0] m02_o,
  output logic signed [VALUE_BITS-1:0] m10_o,
  output logic signed [VALUE_BITS-1:0] m11_o,
  output logic signed [VALUE_BITS-1:0] m12_o,
  output logic signed [VALUE_BITS-1:0] m20_o,
  output logic signed [VALUE_BITS-1:0] m21_o,
  output logic signed [VALUE_BITS-1:0] m22_o
);
  import aarm_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int AUX_W = 3 * VB;
  localparam int LAT   = SINCOS_LAT + MATRIX_LAT;

  logic           en;
  logic [LAT-1:0] valid_q, valid_d;

  // pipeline moves unless the output beat is held
  assign en         = !valid_q[LAT-1] || !out_stall_i;
  assign in_stall_o = !en;
  assign valid_d    = en ? {valid_q[LAT-2:0], in_valid_i} : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q[LAT-1];

  logic signed [VB-1:0] cos_w, sin_w;
  logic [AUX_W-1:0]     aux_w;
  logic signed [VB-1:0] m [9];

  aarm_sincos #(
    .VB    (VB),
    .AUX_W (AUX_W)
  ) u_sincos (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (angle_i),
    .aux_i   ({axis_z_i, axis_y_i, axis_x_i}),
    .cos_o   (cos_w),
    .sin_o   (sin_w),
    .aux_o   (aux_w)
  );

  aarm_matrix #(
    .VB (VB)
  ) u_matrix (
    .clk_i (clk_i),
    .en_i  (en),
    .ux_i  (aux_w[VB-1:0]),
    .uy_i  (aux_w[2*VB-1:VB]),
    .uz_i  (aux_w[3*VB-1:2*VB]),
    .cos_i (cos_w),
    .sin_i (sin_w),
    .m_o   (m)
  );

  assign m00_o = m[0];
  assign m01_o = m[1];
  assign m02_o = m[2];
  assign m10_o = m[3];
  assign m11_o = m[4];
  assign m12_o = m[5];
  assign m20_o = m[6];
  assign m21_o = m[7];
  assign m22_o = m[8];

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for axis_angle_to_rotation_matrix_unit.
// Predicts each matrix with a CORDIC and Rodrigues model of its own and checks every beat.
// Needs only the RTL under rtl/ (the top level pulls in aarm_pkg and its submodules).
`timescale 1ns / 1ps

module tb;

  localparam int     VB          = 16;
  localparam int     FRAC        = VB - 2;
  localparam int     ANG_FRAC    = VB - 3;
  localparam longint ONE         = 1 << FRAC;
  localparam longint GAIN        = 64'sh26DD3B6A;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam int     LATENCY     = 37;
  localparam int     PHASE_ITEMS = 250;

  // atan(2^-i) in Q2.30, truncated
  localparam longint ARCTAN_Q30 [30] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002
  };

  typedef enum int {NO_IDLE, SEND_IDLE, RECV_STALL, BOTH_IDLE} idle_mode_e;

  typedef struct packed {
    logic signed [VB-1:0] ax;
    logic signed [VB-1:0] ay;
    logic signed [VB-1:0] az;
    logic signed [VB-1:0] angle;
  } rotation_t;

  // entry k is row k/3, column k%3
  typedef logic [8:0][VB-1:0] matrix_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          out_stall_i = 1'b0;
  logic [VB-1:0] axis_x_i    = '0;
  logic [VB-1:0] axis_y_i    = '0;
  logic [VB-1:0] axis_z_i    = '0;
  logic [VB-1:0] angle_i     = '0;
  logic          in_stall_o, out_valid_o;
  logic [VB-1:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;

  rotation_t  rotation_q [$];
  matrix_t    matrix_q [$];
  idle_mode_e idle_mode = NO_IDLE;
  bit         in_beat   = 1'b0;
  int         errors    = 0;
  int         accepted  = 0;
  int         checked   = 0;
  int         directed  = 0;

  axis_angle_to_rotation_matrix_unit #(
    .VALUE_BITS(VB)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .axis_x_i   (axis_x_i),
    .axis_y_i   (axis_y_i),
    .axis_z_i   (axis_z_i),
    .angle_i    (angle_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .m00_o      (m00_o),
    .m01_o      (m01_o),
    .m02_o      (m02_o),
    .m10_o      (m10_o),
    .m11_o      (m11_o),
    .m12_o      (m12_o),
    .m20_o      (m20_o),
    .m21_o      (m21_o),
    .m22_o      (m22_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // a*b/ONE, rounded half away from zero
  function automatic longint prod_q(longint a, longint b);
    longint mag;
    mag = (a < 0 ? -a : a) * (b < 0 ? -b : b);
    mag = (mag + (ONE >>> 1)) >>> FRAC;
    return ((a < 0) != (b < 0)) ? -mag : mag;
  endfunction

  function automatic longint outer_q(longint a, longint b, longint one_minus_c);
    return prod_q(sat(prod_q(a, b), 4 * ONE), one_minus_c);
  endfunction

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, dx;
    bit     flip;
    x    = GAIN;
    y    = 0;
    flip = 1'b0;
    z    = ang <<< (30 - ANG_FRAC);
    // fold into [-pi/2, pi/2]; cosine changes sign
    if (z > HALF_PI_Q30) begin
      z    = PI_Q30 - z;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z    = -PI_Q30 - z;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      if (z >= 0) begin
        y = y + (x >>> i);
        x = x - dx;
        z = z - ARCTAN_Q30[i];
      end else begin
        y = y - (x >>> i);
        x = x + dx;
        z = z + ARCTAN_Q30[i];
      end
    end
    if (flip) x = -x;
    c = sat((x + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC), ONE);
    s = sat((y + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC), ONE);
  endfunction

  function automatic matrix_t rotation_matrix(rotation_t r);
    longint  ux, uy, uz, c, s, cc, txy, txz, tyz;
    longint  v [9];
    matrix_t m;
    ux = $signed(r.ax);
    uy = $signed(r.ay);
    uz = $signed(r.az);
    sin_cos($signed(r.angle), c, s);
    cc   = ONE - c;
    txy  = outer_q(ux, uy, cc);
    txz  = outer_q(ux, uz, cc);
    tyz  = outer_q(uy, uz, cc);
    v[0] = outer_q(ux, ux, cc) + c;
    v[1] = txy - prod_q(uz, s);
    v[2] = txz + prod_q(uy, s);
    v[3] = txy + prod_q(uz, s);
    v[4] = outer_q(uy, uy, cc) + c;
    v[5] = tyz - prod_q(ux, s);
    v[6] = txz - prod_q(uy, s);
    v[7] = tyz + prod_q(ux, s);
    v[8] = outer_q(uz, uz, cc) + c;
    for (int k = 0; k < 9; k++) m[k] = VB'(sat(v[k], ONE));
    return m;
  endfunction

  function automatic bit rests(bit receiver);
    int roll;
    roll = $urandom_range(99);
    case (idle_mode)
      SEND_IDLE:  return !receiver && roll < 72;
      RECV_STALL: return receiver && roll < 72;
      BOTH_IDLE:  return roll < 26;
      default:    return 1'b0;
    endcase
  endfunction

  task automatic add_rotation(int ax, int ay, int az, int angle);
    rotation_q.push_back('{VB'(ax), VB'(ay), VB'(az), VB'(angle)});
    directed++;
  endtask

  // driver: a new beat goes out only once the previous one was taken
  always @(negedge clk_i) begin
    rotation_t nxt;
    if (rst_ni && (!in_valid_i || in_beat)) begin
      if (rotation_q.size() > 0 && !rests(1'b0)) begin
        nxt = rotation_q.pop_front();
        axis_x_i   <= nxt.ax;
        axis_y_i   <= nxt.ay;
        axis_z_i   <= nxt.az;
        angle_i    <= nxt.angle;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rests(1'b1);
  end

  // monitor: queue the predicted matrix per input beat, check per output beat
  always @(posedge clk_i) begin
    matrix_t got, want;
    in_beat = rst_ni && in_valid_i && !in_stall_o;
    if (in_beat) begin
      matrix_q.push_back(rotation_matrix({axis_x_i, axis_y_i, axis_z_i, angle_i}));
      accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {m22_o, m21_o, m20_o, m12_o, m11_o, m10_o, m02_o, m01_o, m00_o};
      if (matrix_q.size() == 0) begin
        $error("matrix beat with no rotation outstanding");
        errors++;
      end else begin
        want = matrix_q.pop_front();
        checked++;
        for (int k = 0; k < 9; k++) begin
          if (got[k] !== want[k]) begin
            $error("m%0d%0d: expected %0d, got %0d", k / 3, k % 3,
                   $signed(want[k]), $signed(got[k]));
            errors++;
          end
        end
      end
    end
  end

  initial begin
    rotation_t r;
    real       vx, vy, vz, norm;
    int        pick;

    // identity, quarter turns, half turns, fold boundary around pi/2
    add_rotation( 16384,      0,      0,      0);
    add_rotation(     0,  16384,      0,  12868);
    add_rotation(     0,  16384,      0,  12867);
    add_rotation(     0,      0,  16384, -12868);
    add_rotation(     0,      0,  16384,  25736);
    add_rotation( 16384,      0,      0, -25736);
    add_rotation( 11585, -11585,      0,  12869);
    add_rotation(     0,  11585,  11585, -12869);
    add_rotation(  9459,   9459,   9459,   8579);
    add_rotation(-16384,      0,      0,      1);
    add_rotation(     0, -16384,      0,     -1);
    // angles past pi, most negative code
    add_rotation(     0,  16384,      0,  32767);
    add_rotation(     0,      0,  16384, -32768);
    add_rotation( 32767,  32767,  32767, -32768);
    // axes off unit length: zero, too long, at the code extremes
    add_rotation(     0,      0,      0,  10000);
    add_rotation( 16384,  16384,  16384,  12868);
    add_rotation(-32768, -32768, -32768,  25736);
    add_rotation( 32767, -32768,  32767,  20000);
    add_rotation(-32768,  32767, -32768, -20000);
    add_rotation( 16384, -16384,  16384,  -6000);

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_e'(ph);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(9);
        if (pick < 8) begin
          // random unit axis
          do begin
            vx   = real'(int'($urandom_range(32768)) - 16384);
            vy   = real'(int'($urandom_range(32768)) - 16384);
            vz   = real'(int'($urandom_range(32768)) - 16384);
            norm = $sqrt(vx * vx + vy * vy + vz * vz);
          end while (norm < 64.0);
          r.ax = VB'(int'(vx * 16384.0 / norm));
          r.ay = VB'(int'(vy * 16384.0 / norm));
          r.az = VB'(int'(vz * 16384.0 / norm));
          if (pick < 7) r.angle = VB'(int'($urandom_range(51472)) - 25736);
          else r.angle = VB'($urandom);
        end else begin
          r = rotation_t'({$urandom, $urandom});
        end
        rotation_q.push_back(r);
      end
      while (rotation_q.size() > 0) @(posedge clk_i);
    end

    while (in_valid_i || matrix_q.size() > 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("%0d rotations sent (%0d directed, the rest random under four idling patterns),",
             accepted, directed);
    $display("%0d matrices checked, %0d entry mismatches", checked, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
